// ===== rtl/hsu_pkg.sv =====
`timescale 1ns / 1ps

package hsu_pkg;

  localparam int INDEX_BITS = 13;
  localparam int KEY_WIDTH  = 64;
  localparam int LOG_BITS   = INDEX_BITS - 1;
  localparam int SLOT_COUNT = 2 ** INDEX_BITS;
  localparam int LOG_DEPTH  = 2 ** LOG_BITS;
  localparam int HOLD_LIMIT = (SLOT_COUNT - 1) >> 1;
  localparam int ENTRIES_W  = 12;

  localparam logic [63:0] SENTINEL_FULL = 64'hA5B8_5C5E_198E_D849;
  localparam logic [KEY_WIDTH-1:0] SENTINEL = SENTINEL_FULL[KEY_WIDTH-1:0];

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_UNDO   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic                 error;
    logic [ENTRIES_W-1:0] entries;
  } out_t;

  typedef struct packed {
    logic                  we;
    logic [INDEX_BITS-1:0] waddr;
    logic [KEY_WIDTH-1:0]  wdata;
    logic [INDEX_BITS-1:0] raddr;
  } slot_req_t;

  typedef struct packed {
    logic                  we;
    logic [LOG_BITS-1:0]   waddr;
    logic [INDEX_BITS-1:0] wdata;
    logic [LOG_BITS-1:0]   raddr;
  } log_req_t;

endpackage

// ===== rtl/hash_set_with_undo_log_unit.sv =====
`timescale 1ns / 1ps
// Insert and lookup probe from the home slot to an empty slot or, for lookup, a match; undo
// empties the last logged slot, clear all of them; refused or trivial ops answer from idle.
// Throughput: one operation at a time; probes run one slot per cycle on the slot memory port.
// Reset: after rst_n every slot of the slot memory is swept to empty with busy held high.
// Results appear for one cycle on out_valid; the receiver cannot stall.
module hash_set_with_undo_log_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hsu_pkg::in_t   in_item,
  output logic           out_valid,
  output hsu_pkg::out_t  out_item
);

  hsu_pkg::slot_req_t              slot_req;
  hsu_pkg::log_req_t               log_req;
  logic [hsu_pkg::KEY_WIDTH-1:0]   slot_rdata;
  logic [hsu_pkg::INDEX_BITS-1:0]  log_rdata;

  hsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .slot_req   (slot_req),
    .slot_rdata (slot_rdata),
    .log_req    (log_req),
    .log_rdata  (log_rdata)
  );

  hsu_slot_mem u_slot_mem (
    .clk   (clk),
    .req   (slot_req),
    .rdata (slot_rdata)
  );

  hsu_log_mem u_log_mem (
    .clk   (clk),
    .req   (log_req),
    .rdata (log_rdata)
  );

endmodule

// ===== rtl/hsu_slot_mem.sv =====
`timescale 1ns / 1ps

module hsu_slot_mem (
  input  logic                            clk,
  input  hsu_pkg::slot_req_t              req,
  output logic [hsu_pkg::KEY_WIDTH-1:0]   rdata
);

  logic [hsu_pkg::KEY_WIDTH-1:0] mem [hsu_pkg::SLOT_COUNT];
  logic [hsu_pkg::KEY_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hsu_log_mem.sv =====
`timescale 1ns / 1ps

module hsu_log_mem (
  input  logic                             clk,
  input  hsu_pkg::log_req_t                req,
  output logic [hsu_pkg::INDEX_BITS-1:0]   rdata
);

  logic [hsu_pkg::INDEX_BITS-1:0] mem [hsu_pkg::LOG_DEPTH];
  logic [hsu_pkg::INDEX_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hsu_ctrl.sv =====
`timescale 1ns / 1ps

module hsu_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  hsu_pkg::in_t                     in_item,
  output logic                             out_valid,
  output hsu_pkg::out_t                    out_item,
  output hsu_pkg::slot_req_t               slot_req,
  input  logic [hsu_pkg::KEY_WIDTH-1:0]    slot_rdata,
  output hsu_pkg::log_req_t                log_req,
  input  logic [hsu_pkg::INDEX_BITS-1:0]   log_rdata
);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_UNDO  = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [hsu_pkg::INDEX_BITS-1:0]  init_addr_r, init_addr_nxt;
  logic [hsu_pkg::LOG_BITS-1:0]    count_r, count_nxt;
  logic [hsu_pkg::LOG_BITS-1:0]    clr_idx_r, clr_idx_nxt;
  logic [hsu_pkg::INDEX_BITS-1:0]  pos_r, pos_nxt;
  logic [hsu_pkg::KEY_WIDTH-1:0]   key_r, key_nxt;
  logic                            is_insert_r, is_insert_nxt;
  logic                            out_valid_r, out_valid_nxt;
  hsu_pkg::out_t                   out_item_r, out_item_nxt;
  logic [hsu_pkg::KEY_WIDTH-1:0]   in_key;

  function automatic hsu_pkg::out_t make_result(
    input logic                         found,
    input logic                         error,
    input logic [hsu_pkg::LOG_BITS-1:0] count
  );
    hsu_pkg::out_t res;
    logic [31:0]   wide;
    wide        = 32'(count);
    res.found   = found;
    res.error   = error;
    res.entries = wide[hsu_pkg::ENTRIES_W-1:0];
    return res;
  endfunction

  assign in_key = in_item.key[hsu_pkg::KEY_WIDTH-1:0];

  always_comb begin
    state_nxt     = state_r;
    init_addr_nxt = init_addr_r;
    count_nxt     = count_r;
    clr_idx_nxt   = clr_idx_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    is_insert_nxt = is_insert_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    slot_req.we    = 1'b0;
    slot_req.waddr = pos_r;
    slot_req.wdata = key_r;
    slot_req.raddr = pos_r;
    log_req.we     = 1'b0;
    log_req.waddr  = count_r;
    log_req.wdata  = pos_r;
    log_req.raddr  = clr_idx_r;

    case (state_r)
      ST_INIT: begin
        // sweep every slot to empty after reset
        slot_req.we    = 1'b1;
        slot_req.waddr = init_addr_r;
        slot_req.wdata = hsu_pkg::SENTINEL;
        init_addr_nxt  = init_addr_r + hsu_pkg::INDEX_BITS'(1);
        if (&init_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        slot_req.raddr = in_key[hsu_pkg::INDEX_BITS-1:0];
        if (start) begin
          key_nxt = in_key;
          pos_nxt = in_key[hsu_pkg::INDEX_BITS-1:0];
          case (in_item.operation)
            hsu_pkg::OP_INSERT: begin
              if (in_key == hsu_pkg::SENTINEL ||
                  count_r >= hsu_pkg::LOG_BITS'(hsu_pkg::HOLD_LIMIT)) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = make_result(1'b0, 1'b1, count_r);
              end else begin
                is_insert_nxt = 1'b1;
                state_nxt     = ST_PROBE;
              end
            end
            hsu_pkg::OP_LOOKUP: begin
              if (in_key == hsu_pkg::SENTINEL) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = make_result(1'b0, 1'b0, count_r);
              end else begin
                is_insert_nxt = 1'b0;
                state_nxt     = ST_PROBE;
              end
            end
            hsu_pkg::OP_UNDO: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = make_result(1'b0, 1'b1, count_r);
              end else begin
                log_req.raddr = count_r - hsu_pkg::LOG_BITS'(1);
                state_nxt     = ST_UNDO;
              end
            end
            default: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = make_result(1'b0, 1'b0, count_r);
              end else begin
                log_req.raddr = '0;
                clr_idx_nxt   = '0;
                state_nxt     = ST_CLEAR;
              end
            end
          endcase
        end
      end

      ST_PROBE: begin
        if (slot_rdata == hsu_pkg::SENTINEL) begin
          if (is_insert_r) begin
            slot_req.we   = 1'b1;
            log_req.we    = 1'b1;
            count_nxt     = count_r + hsu_pkg::LOG_BITS'(1);
            out_item_nxt  = make_result(1'b0, 1'b0, count_r + hsu_pkg::LOG_BITS'(1));
          end else begin
            out_item_nxt  = make_result(1'b0, 1'b0, count_r);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!is_insert_r && slot_rdata == key_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = make_result(1'b1, 1'b0, count_r);
          state_nxt     = ST_IDLE;
        end else begin
          // advance to the next slot, wrapping at the end of the table
          pos_nxt        = pos_r + hsu_pkg::INDEX_BITS'(1);
          slot_req.raddr = pos_r + hsu_pkg::INDEX_BITS'(1);
        end
      end

      ST_UNDO: begin
        slot_req.we    = 1'b1;
        slot_req.waddr = log_rdata;
        slot_req.wdata = hsu_pkg::SENTINEL;
        count_nxt      = count_r - hsu_pkg::LOG_BITS'(1);
        out_valid_nxt  = 1'b1;
        out_item_nxt   = make_result(1'b0, 1'b0, count_r - hsu_pkg::LOG_BITS'(1));
        state_nxt      = ST_IDLE;
      end

      ST_CLEAR: begin
        slot_req.we    = 1'b1;
        slot_req.waddr = log_rdata;
        slot_req.wdata = hsu_pkg::SENTINEL;
        if (clr_idx_r + hsu_pkg::LOG_BITS'(1) == count_r) begin
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
          out_item_nxt  = make_result(1'b0, 1'b0, '0);
          state_nxt     = ST_IDLE;
        end else begin
          clr_idx_nxt   = clr_idx_r + hsu_pkg::LOG_BITS'(1);
          log_req.raddr = clr_idx_r + hsu_pkg::LOG_BITS'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_addr_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_idx_r   <= clr_idx_nxt;
    pos_r       <= pos_nxt;
    key_r       <= key_nxt;
    is_insert_r <= is_insert_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  hsu_pkg::in_t  in_item = '0;
  logic          out_valid;
  hsu_pkg::out_t out_item;

  hash_set_with_undo_log_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Set model: slot table, insert log and key count
  logic [hsu_pkg::KEY_WIDTH-1:0]  model_slots [hsu_pkg::SLOT_COUNT];
  logic [hsu_pkg::INDEX_BITS-1:0] model_log   [hsu_pkg::LOG_DEPTH];
  int unsigned                    model_held = 0;

  hsu_pkg::in_t  op_queue[$];
  hsu_pkg::out_t predicted_status[$];
  int   ops_issued = 0;
  int   ops_taken = 0;
  int   fail_count = 0;
  int   mismatch_count = 0;
  bit   took_item = 1'b0;
  bit   no_idle = 1'b0;
  int   gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic hsu_pkg::out_t apply_set_op(hsu_pkg::in_t item);
    logic [hsu_pkg::KEY_WIDTH-1:0]  k;
    logic [hsu_pkg::INDEX_BITS-1:0] pos;
    int unsigned n;
    bit done;
    hsu_pkg::out_t r;
    r = '0;
    k = item.key[hsu_pkg::KEY_WIDTH-1:0];
    pos = k[hsu_pkg::INDEX_BITS-1:0];
    done = 1'b0;
    case (item.operation)
      hsu_pkg::OP_INSERT: begin
        if (k == hsu_pkg::SENTINEL || model_held >= hsu_pkg::HOLD_LIMIT) begin
          r.error = 1'b1;
        end else begin
          for (n = 0; n < hsu_pkg::SLOT_COUNT && !done; n++) begin
            if (model_slots[pos] == hsu_pkg::SENTINEL) begin
              model_slots[pos] = k;
              model_log[model_held[hsu_pkg::LOG_BITS-1:0]] = pos;
              model_held++;
              done = 1'b1;
            end else begin
              pos = pos + hsu_pkg::INDEX_BITS'(1);
            end
          end
          if (!done) r.error = 1'b1;
        end
      end
      hsu_pkg::OP_UNDO: begin
        if (model_held == 0) begin
          r.error = 1'b1;
        end else begin
          model_held--;
          model_slots[model_log[model_held[hsu_pkg::LOG_BITS-1:0]]] = hsu_pkg::SENTINEL;
        end
      end
      hsu_pkg::OP_LOOKUP: begin
        for (n = 0; n < hsu_pkg::SLOT_COUNT && !done; n++) begin
          if (model_slots[pos] == hsu_pkg::SENTINEL) begin
            done = 1'b1;
          end else if (model_slots[pos] == k) begin
            r.found = 1'b1;
            done = 1'b1;
          end else begin
            pos = pos + hsu_pkg::INDEX_BITS'(1);
          end
        end
      end
      default: begin
        for (n = 0; n < model_held && n < hsu_pkg::LOG_DEPTH; n++)
          model_slots[model_log[n[hsu_pkg::LOG_BITS-1:0]]] = hsu_pkg::SENTINEL;
        model_held = 0;
      end
    endcase
    r.entries = model_held[hsu_pkg::ENTRIES_W-1:0];
    return r;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Key clustered around a few home slots, the top of the table included, so probes collide
  // and wrap
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    logic [12:0] low;
    low = 13'($urandom());
    case ($urandom_range(0, 4))
      0: low = 13'h0000 + 13'($urandom_range(0, 7));
      1: low = 13'h1FFC + 13'($urandom_range(0, 7));
      2: low = 13'h0800 + 13'($urandom_range(0, 7));
      3: low = hsu_pkg::SENTINEL[12:0] + 13'($urandom_range(0, 3));
      default: ;
    endcase
    k = {$urandom(), $urandom()};
    k[12:0] = low;
    if (k == hsu_pkg::SENTINEL) k[63] = ~k[63];
    return k;
  endfunction

  task automatic push_op(logic [1:0] op, logic [63:0] key);
    hsu_pkg::in_t item;
    item.operation = op;
    item.key = key;
    op_queue.push_back(item);
    ops_issued++;
  endtask

  task automatic wait_drained();
    while (ops_taken != ops_issued || predicted_status.size() != 0) @(negedge clk);
  endtask

  // Driver: one transfer per accepted start, gap drawn after each
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      // hold until the block takes it
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (op_queue.size() != 0) begin
      in_item <= op_queue.pop_front();
      start <= 1'b1;
      gap_left <= next_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check results, then predict for an item taken at this edge
  always @(posedge clk) begin
    hsu_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (predicted_status.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: found=%0b error=%0b entries=%0d",
                     out_item.found, out_item.error, out_item.entries);
        end else begin
          want = predicted_status.pop_front();
          if (out_item.found !== want.found || out_item.error !== want.error ||
              out_item.entries !== want.entries) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp found=%0b error=%0b entries=%0d, got %0b %0b %0d",
                       want.found, want.error, want.entries,
                       out_item.found, out_item.error, out_item.entries);
          end
        end
      end
      took_item <= start && !busy;
      if (start && !busy) begin
        predicted_status.push_back(apply_set_op(in_item));
        ops_taken++;
      end
    end
  end

  initial begin
    logic [63:0] k;
    logic [63:0] recent[$];
    int r;
    foreach (model_slots[i]) model_slots[i] = hsu_pkg::SENTINEL;
    foreach (model_log[i]) model_log[i] = '0;

    // Empty-set corner cases, probe collisions and wrap, duplicates, undo order
    push_op(hsu_pkg::OP_LOOKUP, 64'h0);
    push_op(hsu_pkg::OP_UNDO, 64'hFFFF_FFFF_FFFF_FFFF);
    push_op(hsu_pkg::OP_CLEAR, 64'h0);
    push_op(hsu_pkg::OP_INSERT, hsu_pkg::SENTINEL);
    push_op(hsu_pkg::OP_LOOKUP, hsu_pkg::SENTINEL);
    push_op(hsu_pkg::OP_INSERT, 64'h0);
    push_op(hsu_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    push_op(hsu_pkg::OP_INSERT, 64'h0000_0000_0000_1FFF);
    push_op(hsu_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_E000);
    push_op(hsu_pkg::OP_INSERT, 64'h0);
    push_op(hsu_pkg::OP_LOOKUP, 64'h0);
    push_op(hsu_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
    push_op(hsu_pkg::OP_LOOKUP, 64'h0000_0000_0000_1FFF);
    push_op(hsu_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_E000);
    push_op(hsu_pkg::OP_LOOKUP, 64'h1);
    push_op(hsu_pkg::OP_INSERT, hsu_pkg::SENTINEL ^ 64'h8000_0000_0000_0000);
    push_op(hsu_pkg::OP_LOOKUP, hsu_pkg::SENTINEL);
    push_op(hsu_pkg::OP_UNDO, 64'h0);
    push_op(hsu_pkg::OP_LOOKUP, hsu_pkg::SENTINEL ^ 64'h8000_0000_0000_0000);
    push_op(hsu_pkg::OP_UNDO, 64'h0);
    push_op(hsu_pkg::OP_UNDO, 64'h0);
    push_op(hsu_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_E000);
    push_op(hsu_pkg::OP_LOOKUP, 64'h0);
    push_op(hsu_pkg::OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
    push_op(hsu_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Random traffic, clustered keys, some phases without idle cycles
    for (int c = 0; c < 7; c++) begin
      no_idle = (c == 2 || c == 5);
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          k = pick_key();
          if (recent.size() != 0 && $urandom_range(0, 9) == 0)
            k = recent[$urandom_range(0, recent.size() - 1)];
          if ($urandom_range(0, 99) == 0) k = hsu_pkg::SENTINEL;
          push_op(hsu_pkg::OP_INSERT, k);
          recent.push_back(k);
          if (recent.size() > 64) void'(recent.pop_front());
        end else if (r < 80) begin
          case ($urandom_range(0, 3))
            0, 1: k = (recent.size() != 0) ? recent[$urandom_range(0, recent.size() - 1)]
                                           : pick_key();
            2: k = pick_key();
            default: k = ($urandom_range(0, 3) == 0) ? hsu_pkg::SENTINEL
                                                     : {$urandom(), $urandom()};
          endcase
          push_op(hsu_pkg::OP_LOOKUP, k);
        end else if (r < 97) begin
          push_op(hsu_pkg::OP_UNDO, {$urandom(), $urandom()});
        end else begin
          push_op(hsu_pkg::OP_CLEAR, {$urandom(), $urandom()});
        end
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && predicted_status.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
